/* hdl/modular_matrix_inverse_solve_top_assert.svh */
// ----------------------------------------------------------------------------
// modular matrix inverse solve assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef MODULAR_MATRIX_INVERSE_SOLVE_TOP_ASSERT_SVH
`define MODULAR_MATRIX_INVERSE_SOLVE_TOP_ASSERT_SVH

// same-cycle implication
`define MMIS_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mmis port check failed");

// next-cycle implication
`define MMIS_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mmis port check failed");

`endif

/* hdl/mmis_pkg.sv */
// ----------------------------------------------------------------------------
// mmis_pkg
// types, codes and helpers of the modular matrix inverse solver
// ----------------------------------------------------------------------------
`default_nettype none

package mmis_pkg;

    localparam int DW              = 16;
    localparam int MAX_ORDER_DEF   = 4;
    localparam int VALUE_WIDTH_DEF = 16;

    localparam logic [1:0] CMD_LOAD_KEY = 2'd0;
    localparam logic [1:0] CMD_LOAD_VEC = 2'd1;
    localparam logic [1:0] CMD_SOLVE    = 2'd2;

    localparam logic [1:0] CFG_SIZE    = 2'd0;
    localparam logic [1:0] CFG_MODULUS = 2'd1;

    localparam logic [2:0]    SIZE_RESET = 3'd3;
    localparam logic [DW-1:0] MOD_RESET  = 16'd26;

    typedef struct packed {
        logic [1:0]    command;
        logic [1:0]    row;
        logic [1:0]    column;
        logic [DW-1:0] value;
    } item_t;

    typedef struct packed {
        logic [1:0]    index;
        logic [DW-1:0] result;
        logic          last;
        logic          singular;
    } answer_t;

    typedef struct packed {
        logic          go;
        logic [DW-1:0] a;
        logic [DW-1:0] b;
        logic [DW-1:0] md;
    } mm_req_t;

    typedef struct packed {
        logic          done;
        logic [DW-1:0] quot;
        logic [DW-1:0] rem;
    } mm_rsp_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_LOAD,
        ST_PINIT,
        ST_MASK,
        ST_COL,
        ST_RDF,
        ST_RDK,
        ST_MUL,
        ST_CRD,
        ST_CWR,
        ST_DRD,
        ST_DET,
        ST_ECHK,
        ST_EDIV,
        ST_ETMUL,
        ST_SING,
        ST_OROW,
        ST_ORDA,
        ST_ORDV,
        ST_OMST,
        ST_OMW,
        ST_OFIN
    } state_t;

    function automatic int mmis_depth(input int n);
        return 2 * n * n + n + (1 << n);
    endfunction

    function automatic logic [DW-1:0] mod_add(input logic [DW-1:0] x,
                                              input logic [DW-1:0] y,
                                              input logic [DW-1:0] m);
        logic [DW:0] s;
        s = {1'b0, x} + {1'b0, y};
        if (s >= {1'b0, m})
            s = s - {1'b0, m};
        return s[DW-1:0];
    endfunction

    function automatic logic [DW-1:0] mod_sub(input logic [DW-1:0] x,
                                              input logic [DW-1:0] y,
                                              input logic [DW-1:0] m);
        logic [DW-1:0] d;
        if (x >= y)
            d = x - y;
        else
            d = x + (m - y);
        return d;
    endfunction

endpackage

`default_nettype wire

/* hdl/mmis_ram.sv */
// ----------------------------------------------------------------------------
// mmis_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module mmis_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* hdl/mmis_mulmod.sv */
// ----------------------------------------------------------------------------
// mmis_mulmod
// bit-serial modular multiplier, a * b mod md, one bit of b per cycle;
// with a = 1 it yields quotient and remainder of b / md
// ----------------------------------------------------------------------------
`default_nettype none

module mmis_mulmod
    import mmis_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire mm_req_t req,
    output mm_rsp_t      rsp
);

    localparam int CNTW = $clog2(DW);

    logic            run_reg;
    logic            done_reg;
    logic [CNTW-1:0] cnt_reg;
    logic [DW-1:0]   a_reg;
    logic [DW-1:0]   b_reg;
    logic [DW-1:0]   md_reg;
    logic [DW-1:0]   acc_reg;
    logic [DW-1:0]   q_reg;

    logic [DW+1:0] s0;
    logic [DW+1:0] s1;
    logic [DW+1:0] s2;
    logic [DW+1:0] mdx;
    logic          ge1;

    always_comb
    begin
        mdx = {2'b00, md_reg};
        s0  = {1'b0, acc_reg, 1'b0} + (b_reg[DW-1] ? {2'b00, a_reg} : '0);
        ge1 = (s0 >= mdx);
        s1  = ge1 ? s0 - mdx : s0;
        s2  = (s1 >= mdx) ? s1 - mdx : s1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.go)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + CNTW'(1);
                if (cnt_reg == CNTW'(DW - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.go)
        begin
            a_reg   <= req.a;
            b_reg   <= req.b;
            md_reg  <= req.md;
            acc_reg <= '0;
            q_reg   <= '0;
        end
        else if (run_reg)
        begin
            acc_reg <= s2[DW-1:0];
            q_reg   <= {q_reg[DW-2:0], ge1};
            b_reg   <= {b_reg[DW-2:0], 1'b0};
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = q_reg;
    assign rsp.rem  = acc_reg;

endmodule

`default_nettype wire

/* hdl/mmis_seq.sv */
// ----------------------------------------------------------------------------
// mmis_seq
// sequencer: loads, minor table over column masks, cofactors, extended
// euclid for the determinant inverse, and the final matrix-vector product
// ----------------------------------------------------------------------------
`default_nettype none

module mmis_seq
    import mmis_pkg::*;
#(
    parameter int MAX_ORDER   = MAX_ORDER_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   start,
    output logic                                        busy,
    input  wire item_t                                  item,
    input  wire logic [$clog2(MAX_ORDER+1)-1:0]         n_eff,
    input  wire logic [DW-1:0]                          m_eff,
    output logic                                        ram_we,
    output logic [$clog2(mmis_depth(MAX_ORDER))-1:0]    ram_waddr,
    output logic [((VALUE_WIDTH > DW) ? VALUE_WIDTH : DW)-1:0] ram_wdata,
    output logic [$clog2(mmis_depth(MAX_ORDER))-1:0]    ram_raddr,
    input  wire logic [((VALUE_WIDTH > DW) ? VALUE_WIDTH : DW)-1:0] ram_rdata,
    output mm_req_t                                     mm_req,
    input  wire mm_rsp_t                                mm_rsp,
    output logic                                        answer_valid,
    output answer_t                                     answer
);

    localparam int N        = MAX_ORDER;
    localparam int IW       = (N > 1) ? $clog2(N) : 1;
    localparam int CW       = $clog2(N + 1);
    localparam int MW       = (VALUE_WIDTH > DW) ? VALUE_WIDTH : DW;
    localparam int DEPTH    = mmis_depth(N);
    localparam int AW       = $clog2(DEPTH);
    localparam int VEC_BASE = N * N;
    localparam int ADJ_BASE = VEC_BASE + N;
    localparam int MIN_BASE = ADJ_BASE + N * N;

    state_t state_reg;
    state_t state_next;

    logic [CW-1:0]  e_reg;
    logic [N-1:0]   mask_reg;
    logic [CW-1:0]  c_reg;
    logic [CW-1:0]  pos_reg;
    logic [CW-1:0]  j_reg;
    logic [CW-1:0]  i_reg;
    logic [DW-1:0]  acc_reg;
    logic [DW-1:0]  opa_reg;
    logic [DW-1:0]  r0_reg;
    logic [DW-1:0]  r1_reg;
    logic [DW-1:0]  t0_reg;
    logic [DW-1:0]  t1_reg;
    logic [AW-1:0]  waddr_reg;
    logic           valid_reg;
    answer_t        ans_reg;

    logic [N-1:0]   full;
    logic [CW-1:0]  pcnt;
    logic [CW-1:0]  kmax;
    logic [CW-1:0]  p;
    logic [CW-1:0]  row_c;
    logic [IW-1:0]  row_idx;
    logic [IW-1:0]  c_idx;
    logic [IW-1:0]  j_idx;
    logic [IW-1:0]  i_idx;
    logic [IW-1:0]  e_idx;
    logic           c_in;
    logic           mask_last;
    logic           term_neg;
    logic           cof_neg;
    logic [N-1:0]   sub_mask;
    logic [N-1:0]   cof_mask;
    logic [DW-1:0]  rd16;
    logic [DW-1:0]  acc_add;
    logic           det_pass;
    logic           j_last;
    logic           i_last;
    logic           key_ok;
    logic           vec_ok;
    logic [AW-1:0]  load_addr;

    always_comb
    begin
        for (int b = 0; b < N; b++)
        begin
            full[b] = (b < int'(n_eff));
        end
    end

    always_comb
    begin
        pcnt      = CW'($countones(mask_reg));
        det_pass  = (e_reg == n_eff);
        kmax      = det_pass ? n_eff : n_eff - CW'(1);
        p         = pcnt - CW'(1);
        row_c     = (p < e_reg) ? p : p + CW'(1);
        row_idx   = row_c[IW-1:0];
        c_idx     = c_reg[IW-1:0];
        j_idx     = j_reg[IW-1:0];
        i_idx     = i_reg[IW-1:0];
        e_idx     = e_reg[IW-1:0];
        c_in      = mask_reg[c_idx];
        mask_last = (mask_reg == full);
        term_neg  = pos_reg[0] ^ p[0];
        cof_neg   = e_reg[0] ^ j_reg[0];
        sub_mask  = mask_reg & ~(N'(1) << c_idx);
        cof_mask  = full & ~(N'(1) << j_idx);
        rd16      = DW'(ram_rdata);
        acc_add   = mod_add(acc_reg, mm_rsp.rem, m_eff);
        j_last    = ((j_reg + CW'(1)) == n_eff);
        i_last    = ((i_reg + CW'(1)) == n_eff);
        key_ok    = (int'(item.row) < N) && (int'(item.column) < N);
        vec_ok    = (int'(item.column) < N);
        if (item.command == CMD_LOAD_KEY)
            load_addr = AW'(item.row) * AW'(N) + AW'(item.column);
        else
            load_addr = AW'(VEC_BASE) + AW'(item.column);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    case (item.command)
                        CMD_LOAD_KEY: if (key_ok) state_next = ST_LOAD;
                        CMD_LOAD_VEC: if (vec_ok) state_next = ST_LOAD;
                        CMD_SOLVE:    state_next = ST_PINIT;
                        default:      state_next = ST_IDLE;
                    endcase
                end
            end
            ST_LOAD:  if (mm_rsp.done) state_next = ST_IDLE;
            ST_PINIT: state_next = ST_MASK;
            ST_MASK:
            begin
                if (pcnt > kmax)
                begin
                    if (mask_last)
                        state_next = det_pass ? ST_DRD : ST_CRD;
                end
                else
                begin
                    state_next = ST_COL;
                end
            end
            ST_COL:
            begin
                if (c_reg == n_eff)
                begin
                    if (mask_last)
                        state_next = det_pass ? ST_DRD : ST_CRD;
                    else
                        state_next = ST_MASK;
                end
                else if (c_in)
                begin
                    state_next = ST_RDF;
                end
            end
            ST_RDF:   state_next = ST_RDK;
            ST_RDK:   state_next = ST_MUL;
            ST_MUL:   if (mm_rsp.done) state_next = ST_COL;
            ST_CRD:   state_next = ST_CWR;
            ST_CWR:   state_next = j_last ? ST_PINIT : ST_CRD;
            ST_DRD:   state_next = ST_DET;
            ST_DET:   state_next = ST_ECHK;
            ST_ECHK:
            begin
                if (r1_reg == '0)
                    state_next = (r0_reg == DW'(1)) ? ST_OROW : ST_SING;
                else
                    state_next = ST_EDIV;
            end
            ST_EDIV:  if (mm_rsp.done) state_next = ST_ETMUL;
            ST_ETMUL: if (mm_rsp.done) state_next = ST_ECHK;
            ST_SING:  state_next = ST_IDLE;
            ST_OROW:  state_next = ST_ORDA;
            ST_ORDA:  state_next = ST_ORDV;
            ST_ORDV:  state_next = ST_OMST;
            ST_OMST:  state_next = ST_OMW;
            ST_OMW:   if (mm_rsp.done) state_next = j_last ? ST_OFIN : ST_ORDA;
            ST_OFIN:  if (mm_rsp.done) state_next = i_last ? ST_IDLE : ST_OROW;
            default:  state_next = ST_IDLE;
        endcase
    end

    // memory and multiplier controls
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = '0;
        ram_raddr = '0;
        mm_req    = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start && (((item.command == CMD_LOAD_KEY) && key_ok) ||
                              ((item.command == CMD_LOAD_VEC) && vec_ok)))
                begin
                    mm_req.go = 1'b1;
                    mm_req.a  = DW'(1);
                    mm_req.b  = item.value;
                    mm_req.md = m_eff;
                end
            end
            ST_LOAD:
            begin
                if (mm_rsp.done)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = waddr_reg;
                    ram_wdata = MW'(VALUE_WIDTH'(mm_rsp.rem));
                end
            end
            ST_PINIT:
            begin
                ram_we    = 1'b1;
                ram_waddr = AW'(MIN_BASE);
                ram_wdata = MW'(1);
            end
            ST_COL:
            begin
                if (c_reg == n_eff)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = AW'(MIN_BASE) + AW'(mask_reg);
                    ram_wdata = MW'(acc_reg);
                end
                else
                begin
                    ram_raddr = AW'(MIN_BASE) + AW'(sub_mask);
                end
            end
            ST_RDF:
            begin
                ram_raddr = AW'(row_idx) * AW'(N) + AW'(c_idx);
            end
            ST_RDK:
            begin
                mm_req.go = 1'b1;
                mm_req.a  = opa_reg;
                mm_req.b  = rd16;
                mm_req.md = m_eff;
            end
            ST_CRD:
            begin
                ram_raddr = AW'(MIN_BASE) + AW'(cof_mask);
            end
            ST_CWR:
            begin
                ram_we    = 1'b1;
                ram_waddr = AW'(ADJ_BASE) + AW'(j_idx) * AW'(N) + AW'(e_idx);
                ram_wdata = MW'(cof_neg ? mod_sub('0, rd16, m_eff) : rd16);
            end
            ST_DRD:
            begin
                ram_raddr = AW'(MIN_BASE) + AW'(full);
            end
            ST_ECHK:
            begin
                if (r1_reg != '0)
                begin
                    mm_req.go = 1'b1;
                    mm_req.a  = DW'(1);
                    mm_req.b  = r0_reg;
                    mm_req.md = r1_reg;
                end
            end
            ST_EDIV:
            begin
                if (mm_rsp.done)
                begin
                    mm_req.go = 1'b1;
                    mm_req.a  = t1_reg;
                    mm_req.b  = mm_rsp.quot;
                    mm_req.md = m_eff;
                end
            end
            ST_ORDA:
            begin
                ram_raddr = AW'(ADJ_BASE) + AW'(i_idx) * AW'(N) + AW'(j_idx);
            end
            ST_ORDV:
            begin
                ram_raddr = AW'(VEC_BASE) + AW'(j_idx);
            end
            ST_OMST:
            begin
                mm_req.go = 1'b1;
                mm_req.a  = opa_reg;
                mm_req.b  = rd16;
                mm_req.md = m_eff;
            end
            ST_OMW:
            begin
                if (mm_rsp.done && j_last)
                begin
                    mm_req.go = 1'b1;
                    mm_req.a  = acc_add;
                    mm_req.b  = t0_reg;
                    mm_req.md = m_eff;
                end
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= ((state_reg == ST_OFIN) && mm_rsp.done) || (state_reg == ST_SING);
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                waddr_reg <= load_addr;
                e_reg     <= '0;
            end
            ST_PINIT:
            begin
                mask_reg <= N'(1);
                j_reg    <= '0;
            end
            ST_MASK:
            begin
                if (pcnt > kmax)
                begin
                    mask_reg <= mask_reg + N'(1);
                end
                else
                begin
                    c_reg   <= '0;
                    pos_reg <= '0;
                    acc_reg <= '0;
                end
            end
            ST_COL:
            begin
                if (c_reg == n_eff)
                    mask_reg <= mask_reg + N'(1);
                else if (!c_in)
                    c_reg <= c_reg + CW'(1);
            end
            ST_RDF:
            begin
                opa_reg <= rd16;
            end
            ST_MUL:
            begin
                if (mm_rsp.done)
                begin
                    acc_reg <= term_neg ? mod_sub(acc_reg, mm_rsp.rem, m_eff) : acc_add;
                    c_reg   <= c_reg + CW'(1);
                    pos_reg <= pos_reg + CW'(1);
                end
            end
            ST_CWR:
            begin
                j_reg <= j_reg + CW'(1);
                if (j_last)
                    e_reg <= e_reg + CW'(1);
            end
            ST_DET:
            begin
                r0_reg <= m_eff;
                r1_reg <= rd16;
                t0_reg <= '0;
                t1_reg <= DW'(1);
            end
            ST_ECHK:
            begin
                i_reg <= '0;
            end
            ST_EDIV:
            begin
                if (mm_rsp.done)
                begin
                    r0_reg <= r1_reg;
                    r1_reg <= mm_rsp.rem;
                end
            end
            ST_ETMUL:
            begin
                if (mm_rsp.done)
                begin
                    t0_reg <= t1_reg;
                    t1_reg <= mod_sub(t0_reg, mm_rsp.rem, m_eff);
                end
            end
            ST_SING:
            begin
                ans_reg.index    <= '0;
                ans_reg.result   <= '0;
                ans_reg.last     <= 1'b1;
                ans_reg.singular <= 1'b1;
            end
            ST_OROW:
            begin
                acc_reg <= '0;
                j_reg   <= '0;
            end
            ST_ORDV:
            begin
                opa_reg <= rd16;
            end
            ST_OMW:
            begin
                if (mm_rsp.done)
                begin
                    acc_reg <= acc_add;
                    j_reg   <= j_reg + CW'(1);
                end
            end
            ST_OFIN:
            begin
                if (mm_rsp.done)
                begin
                    ans_reg.index    <= 2'(i_reg);
                    ans_reg.result   <= mm_rsp.rem;
                    ans_reg.last     <= i_last;
                    ans_reg.singular <= 1'b0;
                    i_reg            <= i_reg + CW'(1);
                end
            end
            default:
            begin
                opa_reg <= opa_reg;
            end
        endcase
    end

    assign busy         = (state_reg != ST_IDLE);
    assign answer_valid = valid_reg;
    assign answer       = ans_reg;

endmodule

`default_nettype wire

/* hdl/modular_matrix_inverse_solve_top.sv */
// ----------------------------------------------------------------------------
// modular_matrix_inverse_solve_top
// Loads an n-by-n key matrix and an n-entry vector reduced mod m, and on a
// solve request returns inv(K) * v mod m, one entry per strobe, or a single
// singular flag when det(K) has no inverse mod m.
//
// A request is taken when start is high and busy is low. Results come as
// one-cycle strobes on answer_valid and cannot be held off. All arithmetic
// runs through one bit-serial modular multiplier; state and the minor table
// live in one ram with registered read. A solve builds the minor table,
// copies the cofactors, runs euclid steps for the determinant inverse and
// then forms the matrix-vector product.
// There is no clearing pass after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module modular_matrix_inverse_solve_top
    import mmis_pkg::*;
#(
    parameter int MAX_ORDER   = MAX_ORDER_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire item_t         item,
    output logic               answer_valid,
    output answer_t            answer,
    input  wire logic          cfg_valid,
    output logic               cfg_ready,
    input  wire logic [1:0]    cfg_index,
    input  wire logic [DW-1:0] cfg_data
);

    localparam int CW    = $clog2(MAX_ORDER + 1);
    localparam int MW    = (VALUE_WIDTH > DW) ? VALUE_WIDTH : DW;
    localparam int DEPTH = mmis_depth(MAX_ORDER);
    localparam int AW    = $clog2(DEPTH);

    logic [2:0]    size_reg;
    logic [DW-1:0] mod_reg;
    logic [CW-1:0] n_eff;
    logic [DW-1:0] m_eff;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [MW-1:0] ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [MW-1:0] ram_rdata;
    mm_req_t       mm_req;
    mm_rsp_t       mm_rsp;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= SIZE_RESET;
            mod_reg  <= MOD_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_SIZE:    size_reg <= cfg_data[2:0];
                CFG_MODULUS: mod_reg  <= cfg_data;
                default:     size_reg <= size_reg;
            endcase
        end
    end

    always_comb
    begin
        if (size_reg == 3'd0)
            n_eff = CW'(1);
        else if (int'(size_reg) > MAX_ORDER)
            n_eff = CW'(MAX_ORDER);
        else
            n_eff = CW'(size_reg);
        m_eff = (mod_reg < DW'(2)) ? DW'(2) : mod_reg;
    end

    mmis_ram #(
        .WIDTH(MW),
        .DEPTH(DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    mmis_mulmod u_mulmod (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mm_req),
        .rsp   (mm_rsp)
    );

    mmis_seq #(
        .MAX_ORDER   (MAX_ORDER),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item),
        .n_eff        (n_eff),
        .m_eff        (m_eff),
        .ram_we       (ram_we),
        .ram_waddr    (ram_waddr),
        .ram_wdata    (ram_wdata),
        .ram_raddr    (ram_raddr),
        .ram_rdata    (ram_rdata),
        .mm_req       (mm_req),
        .mm_rsp       (mm_rsp),
        .answer_valid (answer_valid),
        .answer       (answer)
    );

endmodule

`default_nettype wire

/* hdl/mmis_checker.sv */
// ----------------------------------------------------------------------------
// mmis_checker
// port-level checks of the solver, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "modular_matrix_inverse_solve_top_assert.svh"

module mmis_checker
    import mmis_pkg::*;
(
    input wire logic    clk,
    input wire logic    rst_n,
    input wire logic    start,
    input wire logic    busy,
    input wire item_t   item,
    input wire logic    answer_valid,
    input wire answer_t answer
);

    // singular answer is a single closing result with zero payload
    `MMIS_ASSERT_IMP(a_sing_form, answer_valid && answer.singular, answer.last && answer.index == 2'd0 && answer.result == '0)

    // every result comes out of a running solve
    `MMIS_ASSERT_IMP(a_ans_from_run, answer_valid, $past(busy))

    // a solve request keeps the block occupied
    `MMIS_ASSERT_NXT(a_solve_busy, start && !busy && item.command == CMD_SOLVE, busy)

    // more results follow a non-final one
    `MMIS_ASSERT_NXT(a_more_follow, answer_valid && !answer.last, busy && !answer_valid)

endmodule

bind modular_matrix_inverse_solve_top mmis_checker u_mmis_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .item         (item),
    .answer_valid (answer_valid),
    .answer       (answer)
);

`default_nettype wire
